// File: rtl/core/hlb_pkg.sv
// Shared types, constants and helpers of the hex line parser.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package hlb_pkg;

   localparam int CHAR_W     = 8;
   localparam int COUNT_W    = 32;
   localparam int LINE_CAP   = 8;
   localparam int LEN_W      = 4;
   localparam int STORE_IX_W = 3;
   localparam int BYTES_PER_LINE = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_LF      = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_APOS    = 8'h27;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_H = 8'h48;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_H = 8'h68;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_TOO_LONG = 2'd1,
      STATUS_NO_APOS  = 2'd2,
      STATUS_NO_H     = 2'd3
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] line_count;
      logic [COUNT_W-1:0] invalid_lines;
      logic [COUNT_W-1:0] invalid_chars;
      logic [COUNT_W-1:0] byte_count;
   } counters_type;

   // One finished line (or end of stream) as handed from front to back.
   typedef struct packed {
      logic                                  good;   // three data words, else one status word
      logic                                  done;
      status_type                            status;
      logic [BYTES_PER_LINE-1:0][CHAR_W-1:0] bytes;  // index 0 goes out first
      counters_type                          counters;
   } job_type;

   // {valid, value}; value is zero for a non-hex character
   function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] diff_upper;
      logic [CHAR_W-1:0] diff_lower;
      logic [4:0]        res;
      diff_upper = c - CHAR_UPPER_A;
      diff_lower = c - CHAR_LOWER_A;
      res = 5'b0_0000;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         res = {1'b1, c[3:0]};
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         res = {1'b1, diff_upper[3:0] + 4'd10};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         res = {1'b1, diff_lower[3:0] + 4'd10};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/hex_line_to_bytes_parser.sv
// Top level of the hex line parser: front end, job queue, back end.
// Depends on hlb_pkg, hlb_front, hlb_queue, hlb_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   req     | in        | req_valid/req_ready  | req_char_in, req_end_of_input
//   rsp     | out       | rsp_valid/rsp_ready  | data byte, flags, status, 4 counters
//
// One character is taken per cycle while the job queue has room; a line end
// is taken like any other character. A good line plays out as three result
// words, a rejected line or an end of stream with no pending line as one,
// all from the back end's holding register. The queue (QUEUE_DEPTH jobs)
// lets the front keep taking characters while the back waits on rsp_ready;
// req_ready drops only when the queue is full. Reset is synchronous and
// clears line, counters, queue and the holding register's valid flag.
`default_nettype none

module hex_line_to_bytes_parser #(
   parameter int QUEUE_DEPTH = hlb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_ready,
   input  wire logic [hlb_pkg::CHAR_W-1:0]  req_char_in,
   input  wire logic                        req_end_of_input,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [hlb_pkg::CHAR_W-1:0]  rsp_data_byte,
   output      logic                        rsp_is_data,
   output      logic                        rsp_last,
   output      logic [1:0]                  rsp_line_status,
   output      logic                        rsp_stream_done,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_total_lines,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_invalid_lines,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_invalid_chars,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_bytes_written
);
   import hlb_pkg::*;

   // front -> queue
   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   // queue -> back
   logic    queue_not_empty;
   logic    queue_pop;
   job_type queue_job;

   // line assembly and classification
   hlb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_end_of_input (req_end_of_input),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   // decouples line ends from result back-pressure
   hlb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_job   (queue_job)
   );

   // result word sequencing
   hlb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_not_empty   (queue_not_empty),
      .queue_job         (queue_job),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_is_data       (rsp_is_data),
      .rsp_last          (rsp_last),
      .rsp_line_status   (rsp_line_status),
      .rsp_stream_done   (rsp_stream_done),
      .rsp_total_lines   (rsp_total_lines),
      .rsp_invalid_lines (rsp_invalid_lines),
      .rsp_invalid_chars (rsp_invalid_chars),
      .rsp_bytes_written (rsp_bytes_written)
   );

endmodule

`default_nettype wire

// File: rtl/core/hlb_front.sv
// Front end: accepts characters, assembles the line, classifies it at its end
// and builds one job for the queue. Depends on hlb_pkg.
`default_nettype none

module hlb_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [hlb_pkg::CHAR_W-1:0] req_char_in,
   input  wire logic                       req_end_of_input,
   input  wire logic                       queue_full,
   output      logic                       push_valid,
   output      hlb_pkg::job_type           push_job
);
   import hlb_pkg::*;

   logic [CHAR_W-1:0] store_ff [LINE_CAP];
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              started_ff, started_in;
   counters_type      cnt_ff, cnt_in;

   logic [CHAR_W-1:0] chr [LINE_CAP];
   logic [4:0]        dig [2*BYTES_PER_LINE];
   logic [2:0]        bad_cnt;
   status_type        status;
   logic              accept, is_eol, is_blank, finish, store_char;
   logic [CHAR_W-1:0] stored_char;
   job_type           job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_eol    = (req_char_in == CHAR_LF) || (req_char_in == CHAR_CR);
   assign is_blank  = (req_char_in == CHAR_NUL) || (req_char_in == CHAR_SPACE) ||
                      (req_char_in == CHAR_TAB);
   assign finish    = accept && (req_end_of_input || (is_eol && started_ff));
   assign store_char = accept && !req_end_of_input && !is_eol && !(is_blank && !started_ff);
   assign stored_char = is_blank ? CHAR_SPACE : req_char_in;

   // positions at or past the length read as zero
   always_comb begin
      for (int i = 0; i < LINE_CAP; i++) begin
         chr[i] = (LEN_W'(i) < len_ff) ? store_ff[i] : CHAR_NUL;
      end
      for (int k = 0; k < 2*BYTES_PER_LINE; k++) begin
         dig[k] = hex_digit(chr[k+2]);
      end
   end

   always_comb begin
      if (len_ff > LEN_W'(LINE_CAP)) begin
         status = STATUS_TOO_LONG;
      end else if (chr[0] != CHAR_APOS) begin
         status = STATUS_NO_APOS;
      end else if (chr[1] != CHAR_LOWER_H && chr[1] != CHAR_UPPER_H) begin
         status = STATUS_NO_H;
      end else begin
         status = STATUS_GOOD;
      end
   end

   always_comb begin
      bad_cnt = 3'd0;
      for (int k = 0; k < 2*BYTES_PER_LINE; k++) begin
         bad_cnt = bad_cnt + {2'b00, !dig[k][4]};
      end
   end

   always_comb begin
      job          = '0;
      job.done     = req_end_of_input;
      job.status   = STATUS_GOOD;
      // first word from chars 6-7, then 4-5, then 2-3; a bad digit gives a zero nibble
      for (int b = 0; b < BYTES_PER_LINE; b++) begin
         job.bytes[b] = {dig[4-2*b][4] ? dig[4-2*b][3:0] : 4'h0,
                         dig[5-2*b][4] ? dig[5-2*b][3:0] : 4'h0};
      end
      cnt_in = cnt_ff;
      if (finish && len_ff != '0) begin
         cnt_in.line_count = cnt_ff.line_count + COUNT_W'(1);
         if (status != STATUS_GOOD) begin
            cnt_in.invalid_lines = cnt_ff.invalid_lines + COUNT_W'(1);
            job.status = status;
         end else begin
            job.good = 1'b1;
            cnt_in.invalid_chars = cnt_ff.invalid_chars + COUNT_W'(bad_cnt);
            cnt_in.byte_count    = cnt_ff.byte_count + COUNT_W'(BYTES_PER_LINE);
         end
      end
      if (!job.good) begin
         job.bytes = '0;
      end
      job.counters = cnt_in;
   end

   assign push_valid = finish;
   assign push_job   = job;

   always_comb begin
      len_in     = len_ff;
      started_in = started_ff;
      if (finish || (accept && req_end_of_input)) begin
         len_in     = '0;
         started_in = 1'b0;
      end else if (store_char) begin
         started_in = 1'b1;
         if (len_ff <= LEN_W'(LINE_CAP)) begin
            len_in = len_ff + LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         started_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         len_ff     <= len_in;
         started_ff <= started_in;
         cnt_ff     <= cnt_in;
      end
   end

   // entries past the length are masked on read, so no clearing needed
   always_ff @(posedge clock) begin
      if (store_char && len_ff < LEN_W'(LINE_CAP)) begin
         store_ff[len_ff[STORE_IX_W-1:0]] <= stored_char;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hlb_queue.sv
// Small job FIFO between front and back ends.
// Depends on hlb_pkg for the job type.
`default_nettype none

module hlb_queue #(
   parameter int DEPTH = hlb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire hlb_pkg::job_type push_job,
   output      logic             full,
   input  wire logic             pop,
   output      logic             not_empty,
   output      hlb_pkg::job_type pop_job
);
   import hlb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hlb_back.sv
// Back end: takes jobs from the queue and plays them out as result words
// from a holding register. Depends on hlb_pkg.
`default_nettype none

module hlb_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        queue_not_empty,
   input  wire hlb_pkg::job_type            queue_job,
   output      logic                        queue_pop,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [hlb_pkg::CHAR_W-1:0]  rsp_data_byte,
   output      logic                        rsp_is_data,
   output      logic                        rsp_last,
   output      logic [1:0]                  rsp_line_status,
   output      logic                        rsp_stream_done,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_total_lines,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_invalid_lines,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_invalid_chars,
   output      logic [hlb_pkg::COUNT_W-1:0] rsp_bytes_written
);
   import hlb_pkg::*;

   job_type    job_ff, job_in;
   logic       valid_ff, valid_in;
   logic [1:0] beat_ff, beat_in;
   logic       last_beat;

   assign last_beat = !job_ff.good || (beat_ff == 2'(BYTES_PER_LINE-1));
   assign queue_pop = queue_not_empty && (!valid_ff || (rsp_ready && last_beat));

   always_comb begin
      job_in   = job_ff;
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (queue_pop) begin
         job_in   = queue_job;
         valid_in = 1'b1;
         beat_in  = 2'd0;
      end else if (valid_ff && rsp_ready) begin
         if (last_beat) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_comb begin
      case (beat_ff)
         2'd0:    rsp_data_byte = job_ff.bytes[0];
         2'd1:    rsp_data_byte = job_ff.bytes[1];
         2'd2:    rsp_data_byte = job_ff.bytes[2];
         default: rsp_data_byte = '0;
      endcase
   end

   assign rsp_valid         = valid_ff;
   assign rsp_is_data       = job_ff.good;
   assign rsp_last          = last_beat;
   assign rsp_line_status   = job_ff.status;
   assign rsp_stream_done   = job_ff.done;
   assign rsp_total_lines   = job_ff.counters.line_count;
   assign rsp_invalid_lines = job_ff.counters.invalid_lines;
   assign rsp_invalid_chars = job_ff.counters.invalid_chars;
   assign rsp_bytes_written = job_ff.counters.byte_count;

endmodule

`default_nettype wire
